[sv/tccw_pkg.sv]
// Shared types and constants for the text console character writer.
// Used by the sequencer and the top level; no dependencies.
package tccw_pkg;

  localparam int MAX_COLS_DEF   = 80;
  localparam int MAX_ROWS_P_DEF = 30;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [1:0] TAB_REST = 2'd3;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] REG_FILL_COLOR   = 2'd0;
  localparam logic [1:0] REG_VISIBLE_COLS = 2'd1;
  localparam logic [1:0] REG_VISIBLE_ROWS = 2'd2;

  localparam logic [7:0] FILL_COLOR_RST   = 8'd15;
  localparam logic [6:0] VISIBLE_COLS_RST = 7'd80;
  localparam logic [4:0] VISIBLE_ROWS_RST = 5'd25;

  typedef struct packed {
    logic [7:0] fill_color;
    logic [6:0] visible_cols;
    logic [4:0] visible_rows;
  } cfg_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_SCROLL,
    S_FILL,
    S_CLEAR,
    S_READ
  } state_t;

endpackage

[sv/tccw_cell_mem.sv]
// Cell store: single-port-write, single-port-read synchronous RAM.
// Read data is registered, available in the cycle after the address; no dependencies.
module tccw_cell_mem #(
  parameter int DEPTH = 2400,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/tccw_seq.sv]
// Sequencer: cursor, put/scroll/clear/read walks over the cell store and result words.
// Depends on tccw_pkg; drives the ports of tccw_cell_mem.
module tccw_seq import tccw_pkg::*; #(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS_P = MAX_ROWS_P_DEF,
  localparam int NCELLS = MAX_COLS * MAX_ROWS_P,
  localparam int AW = (NCELLS > 1) ? $clog2(NCELLS) : 1,
  localparam int CW = $clog2(NCELLS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    mode,
  input  logic [7:0]    char_code,
  input  logic [7:0]    attr,
  input  logic [11:0]   read_index,
  output logic          strobe,
  output logic          wrote,
  output logic [11:0]   cell_index,
  output logic [15:0]   cell_value,
  output logic [15:0]   read_data,
  output logic [6:0]    cursor_col,
  output logic [4:0]    cursor_row,
  output logic          scrolled,
  output logic          last,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [15:0]   mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [15:0]   mem_rdata
);

  localparam logic [6:0] COL_CAP = 7'((MAX_COLS < 127) ? MAX_COLS : 127);
  localparam logic [4:0] ROW_CAP = 5'((MAX_ROWS_P < 31) ? MAX_ROWS_P : 31);
  localparam logic [CW-1:0] LAST_CELL = CW'(NCELLS - 1);

  state_t state, state_next;

  logic [6:0]    cur_col;
  logic [4:0]    cur_row;
  logic [7:0]    ch;
  logic [7:0]    at;
  logic [1:0]    tab_left;
  logic          rd_oob;
  logic [7:0]    fill;
  logic [6:0]    cols;
  logic [4:0]    rows;
  logic [CW-1:0] keep;
  logic [CW-1:0] total;
  logic [CW-1:0] sc;
  logic          pend;
  logic [AW-1:0] pend_addr;

  logic [6:0]  cols_e;
  logic [4:0]  rows_e;
  logic [11:0] keep_prod;
  logic [11:0] total_prod;

  logic [6:0]  col_sat;
  logic [4:0]  row_sat;
  logic [12:0] idx13;
  logic        is_nl;
  logic [7:0]  col_inc;
  logic        wrap;
  logic [5:0]  row_cand;
  logic        need_scroll;
  logic [6:0]  new_col;
  logic [4:0]  new_row;
  logic        walk_end;

  // effective geometry from the registers, taken at accept
  always_comb begin
    if (cfg.visible_cols == 7'd0) begin
      cols_e = 7'd1;
    end else if (cfg.visible_cols > COL_CAP) begin
      cols_e = COL_CAP;
    end else begin
      cols_e = cfg.visible_cols;
    end
    if (cfg.visible_rows == 5'd0) begin
      rows_e = 5'd1;
    end else if (cfg.visible_rows > ROW_CAP) begin
      rows_e = ROW_CAP;
    end else begin
      rows_e = cfg.visible_rows;
    end
    keep_prod  = {7'd0, rows_e - 5'd1} * {5'd0, cols_e};
    total_prod = {7'd0, rows_e} * {5'd0, cols_e};
  end

  // one put at the cursor
  always_comb begin
    col_sat     = (cur_col >= cols) ? cols - 7'd1 : cur_col;
    row_sat     = (cur_row >= rows) ? rows - 5'd1 : cur_row;
    idx13       = 13'({7'd0, row_sat} * {5'd0, cols}) + {6'd0, col_sat};
    is_nl       = (ch == CH_NL);
    col_inc     = {1'b0, col_sat} + 8'd1;
    wrap        = !is_nl && (col_inc >= {1'b0, cols});
    row_cand    = (is_nl || wrap) ? {1'b0, row_sat} + 6'd1 : {1'b0, row_sat};
    need_scroll = (row_cand >= {1'b0, rows});
    new_col     = (is_nl || wrap) ? 7'd0 : col_inc[6:0];
    new_row     = need_scroll ? rows - 5'd1 : row_cand[4:0];
    walk_end    = (sc == total - CW'(1));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sc == LAST_CELL) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (mode)
            MODE_PUT:   state_next = S_PUT;
            MODE_READ:  state_next = S_READ;
            MODE_CLEAR: state_next = S_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_PUT: begin
        if (need_scroll) begin
          state_next = S_SCROLL;
        end else if (tab_left == 2'd0) begin
          state_next = S_IDLE;
        end
      end
      S_SCROLL: begin
        if (sc >= keep && !pend) state_next = S_FILL;
      end
      S_FILL: begin
        if (walk_end) state_next = (tab_left != 2'd0) ? S_PUT : S_IDLE;
      end
      S_CLEAR: begin
        if (walk_end) state_next = S_IDLE;
      end
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = sc[AW-1:0];
    mem_wdata = {fill, CH_SPACE};
    mem_raddr = AW'(read_index);
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = 16'd0;
      end
      S_PUT: begin
        mem_we    = !is_nl;
        mem_waddr = AW'(idx13);
        mem_wdata = {at, ch};
      end
      S_SCROLL: begin
        mem_we    = pend;
        mem_waddr = pend_addr;
        mem_wdata = mem_rdata;
        mem_raddr = AW'(sc + CW'(cols));
      end
      S_FILL, S_CLEAR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sc       <= '0;
      pend     <= 1'b0;
      strobe   <= 1'b0;
      cur_col  <= 7'd0;
      cur_row  <= 5'd0;
      tab_left <= 2'd0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      case (state)
        S_INIT: begin
          sc <= sc + CW'(1);
        end
        S_IDLE: begin
          if (start) begin
            ch       <= (mode == MODE_PUT && char_code == CH_TAB) ? CH_SPACE : char_code;
            at       <= attr;
            tab_left <= (mode == MODE_PUT && char_code == CH_TAB) ? TAB_REST : 2'd0;
            rd_oob   <= (32'(read_index) >= NCELLS);
            fill     <= cfg.fill_color;
            cols     <= cols_e;
            rows     <= rows_e;
            keep     <= CW'(keep_prod);
            total    <= CW'(total_prod);
            sc       <= '0;
            pend     <= 1'b0;
            if (mode != MODE_PUT && mode != MODE_READ && mode != MODE_CLEAR) begin
              strobe     <= 1'b1;
              wrote      <= 1'b0;
              cell_index <= 12'd0;
              cell_value <= 16'd0;
              read_data  <= 16'd0;
              cursor_col <= cur_col;
              cursor_row <= cur_row;
              scrolled   <= 1'b0;
              last       <= 1'b1;
            end
          end
        end
        S_PUT: begin
          cur_col    <= new_col;
          cur_row    <= new_row;
          wrote      <= !is_nl;
          cell_index <= is_nl ? 12'd0 : idx13[11:0];
          cell_value <= is_nl ? 16'd0 : {at, ch};
          read_data  <= 16'd0;
          cursor_col <= new_col;
          cursor_row <= new_row;
          scrolled   <= need_scroll;
          last       <= (tab_left == 2'd0);
          strobe     <= !need_scroll;
          sc         <= '0;
          pend       <= 1'b0;
          if (!need_scroll && tab_left != 2'd0) tab_left <= tab_left - 2'd1;
        end
        S_SCROLL: begin
          if (sc < keep) begin
            pend      <= 1'b1;
            pend_addr <= sc[AW-1:0];
            sc        <= sc + CW'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        S_FILL: begin
          sc <= sc + CW'(1);
          if (walk_end) begin
            strobe <= 1'b1;
            if (tab_left != 2'd0) tab_left <= tab_left - 2'd1;
          end
        end
        S_CLEAR: begin
          sc <= sc + CW'(1);
          if (walk_end) begin
            strobe     <= 1'b1;
            wrote      <= 1'b0;
            cell_index <= 12'd0;
            cell_value <= 16'd0;
            read_data  <= 16'd0;
            cursor_col <= cur_col;
            cursor_row <= cur_row;
            scrolled   <= 1'b0;
            last       <= 1'b1;
          end
        end
        S_READ: begin
          strobe     <= 1'b1;
          wrote      <= 1'b0;
          cell_index <= 12'd0;
          cell_value <= 16'd0;
          read_data  <= rd_oob ? 16'd0 : mem_rdata;
          cursor_col <= cur_col;
          cursor_row <= cur_row;
          scrolled   <= 1'b0;
          last       <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/text_console_char_writer.sv]
// Text console character writer: top level with configuration registers.
// Depends on tccw_pkg, tccw_seq and tccw_cell_mem.
//
//   channel  handshake              payload
//   command  start & !busy          mode, char_code, attr, read_index
//   result   strobe (one cycle)     wrote, cell_index, cell_value, read_data,
//                                   cursor_col, cursor_row, scrolled, last
//   config   wr_en                  wr_index, wr_data
//
// Printed character, newline or read: the word is latched at accept, then the put
// state writes the RAM (none for newline) or the read state takes the RAM data,
// and the result is registered. Tab: four puts in a row. A scroll copies
// (rows-1)*cols cells up a row and fills the cols cells of the bottom row; clear
// writes rows*cols cells. After reset busy stays high while all MAX_COLS*MAX_ROWS_P
// cells (2400 by default) are zeroed. Results cannot be held off by the receiver.
module text_console_char_writer import tccw_pkg::*; #(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS_P = MAX_ROWS_P_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [7:0]  wr_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [7:0]  attr,
  input  logic [11:0] read_index,
  output logic        strobe,
  output logic        wrote,
  output logic [11:0] cell_index,
  output logic [15:0] cell_value,
  output logic [15:0] read_data,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic        scrolled,
  output logic        last
);

  localparam int NCELLS = MAX_COLS * MAX_ROWS_P;
  localparam int AW = (NCELLS > 1) ? $clog2(NCELLS) : 1;

  cfg_t cfg;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_color   <= FILL_COLOR_RST;
      cfg.visible_cols <= VISIBLE_COLS_RST;
      cfg.visible_rows <= VISIBLE_ROWS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_FILL_COLOR:   cfg.fill_color   <= wr_data;
        REG_VISIBLE_COLS: cfg.visible_cols <= wr_data[6:0];
        REG_VISIBLE_ROWS: cfg.visible_rows <= wr_data[4:0];
        default: begin
        end
      endcase
    end
  end

  tccw_seq #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS_P (MAX_ROWS_P)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .char_code  (char_code),
    .attr       (attr),
    .read_index (read_index),
    .strobe     (strobe),
    .wrote      (wrote),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .read_data  (read_data),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled),
    .last       (last),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  tccw_cell_mem #(
    .DEPTH (NCELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
